FILE: rtl/sblfu_pkg.sv
// ----------------------------------------------------------------------------
// sblfu_pkg
// Shared types and constants for the byte-budget LFU cache metadata table.
// ----------------------------------------------------------------------------
package sblfu_pkg;

    localparam int BYTES_W = 24;
    localparam int VIS_W   = 32;
    localparam int STAMP_W = 32;

    localparam logic [BYTES_W-1:0] CAP_RESET = 24'h100000;
    localparam logic [VIS_W-1:0]   VIS_MAX   = '1;
    localparam logic [VIS_W-1:0]   VIS_NEW   = 32'd1;

    typedef enum logic [2:0] {
        ST_MISS   = 3'd0,
        ST_HIT    = 3'd1,
        ST_ADDED  = 3'd2,
        ST_EVICT  = 3'd3,
        ST_REJECT = 3'd4
    } t_status;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } t_cmd;

    // ranking of a table entry during a scan
    typedef struct packed {
        logic               found;
        logic [STAMP_W-1:0] age;
        logic [VIS_W-1:0]   visits;
    } t_rank;

endpackage

FILE: rtl/sblfu_req_if.sv
// ----------------------------------------------------------------------------
// sblfu_req_if
// Request channel: lookup or insert command with key and object size.
// ----------------------------------------------------------------------------
interface sblfu_req_if
    import sblfu_pkg::*;
#(
    parameter int KEY_BITS = 64
) ();
    logic                valid;
    logic                ready;
    logic                command;
    logic [KEY_BITS-1:0] key;
    logic [BYTES_W-1:0]  object_bytes;

    modport source (output valid, command, key, object_bytes, input ready);
    modport sink   (input valid, command, key, object_bytes, output ready);
endinterface

FILE: rtl/sblfu_rsp_if.sv
// ----------------------------------------------------------------------------
// sblfu_rsp_if
// Response channel: outcome of one request and table occupancy after it.
// ----------------------------------------------------------------------------
interface sblfu_rsp_if
    import sblfu_pkg::*;
#(
    parameter int KEY_BITS = 64,
    parameter int SLOT_W   = 4,
    parameter int CNT_W    = 5
) ();
    logic                valid;
    logic                ready;
    t_status             status;
    logic [SLOT_W-1:0]   slot;
    logic [VIS_W-1:0]    visits;
    logic [KEY_BITS-1:0] evicted_key;
    logic [BYTES_W-1:0]  evicted_bytes;
    logic [BYTES_W-1:0]  used_bytes;
    logic [CNT_W-1:0]    entry_count;

    modport source (output valid, status, slot, visits, evicted_key, evicted_bytes,
                    used_bytes, entry_count, input ready);
    modport sink   (input valid, status, slot, visits, evicted_key, evicted_bytes,
                    used_bytes, entry_count, output ready);
endinterface

FILE: rtl/sblfu_cmp.sv
// ----------------------------------------------------------------------------
// sblfu_cmp
// Shared rank unit: ages one entry and decides if it beats the current pick.
// ----------------------------------------------------------------------------
module sblfu_cmp
    import sblfu_pkg::*;
#(
    parameter int KEY_BITS = 64
) (
    input  logic                i_mode_ins,
    input  logic                i_cand_valid,
    input  logic [KEY_BITS-1:0] i_cand_key,
    input  logic [VIS_W-1:0]    i_cand_visits,
    input  logic [STAMP_W-1:0]  i_cand_stamp,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [STAMP_W-1:0]  i_next_stamp,
    input  t_rank               i_best,
    output logic                o_take,
    output t_rank               o_cand
);
    logic [STAMP_W-1:0] age;
    logic               eligible;
    logic               older;
    logic               better;

    // age wraps mod 2^32, larger means older
    assign age      = i_next_stamp - i_cand_stamp;
    assign eligible = i_cand_valid && (i_mode_ins || (i_cand_key == i_key));
    assign older    = age > i_best.age;

    always_comb begin
        if (!i_best.found) begin
            better = 1'b1;
        end else if (i_mode_ins) begin
            better = (i_cand_visits < i_best.visits) ||
                     ((i_cand_visits == i_best.visits) && older);
        end else begin
            better = older;
        end
    end

    assign o_take = eligible && better;
    assign o_cand = '{found: 1'b1, age: age, visits: i_cand_visits};
endmodule

FILE: rtl/sblfu_table.sv
// ----------------------------------------------------------------------------
// sblfu_table
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sblfu_table #(
    parameter int ENTRIES = 16,
    parameter int REC_W   = 153
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  logic [REC_W-1:0]           i_wr_data,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output logic [REC_W-1:0]           o_rd_data
);
    logic [REC_W-1:0] mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end
endmodule

FILE: rtl/size_budget_lfu_cache_table.sv
// ----------------------------------------------------------------------------
// size_budget_lfu_cache_table
// LFU metadata table for an object cache with a byte budget. Lookups hit
// the oldest matching entry; inserts fill a free slot or evict the least
// visited (oldest on ties) entry when the budget allows.
// ----------------------------------------------------------------------------
//   channel   dir   handshake      contents
//   i_req     in    valid/ready    command, key, object_bytes
//   o_rsp     out   valid/ready    status, slot, visits, evicted_key/bytes,
//                                  used_bytes, entry_count
//   i_cfg     in    write enable   capacity_bytes
//
// After a request is accepted, the table is scanned one entry per cycle
// through the single read port of the entry store and one rank unit.
// After reset a clearing pass runs with i_req.ready low.
// A stalled response beat holds; no request is taken until it is taken.
// ----------------------------------------------------------------------------
module size_budget_lfu_cache_table
    import sblfu_pkg::*;
#(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sblfu_req_if.sink          i_req,
    sblfu_rsp_if.source        o_rsp,
    input  logic               i_cfg_we,
    input  logic [BYTES_W-1:0] i_cfg_wdata
);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int REC_W = 1 + KEY_BITS + BYTES_W + VIS_W + STAMP_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_DECIDE = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [IDX_W-1:0]    r_addr;
    logic                r_dv;
    logic [IDX_W-1:0]    r_didx;
    logic [BYTES_W-1:0]  r_cap;
    logic [STAMP_W-1:0]  r_stamp;
    logic [BYTES_W-1:0]  r_biu;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_free_found;

    // request and scan payload
    logic                r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [BYTES_W-1:0]  r_obj;
    t_rank               r_best;
    logic [IDX_W-1:0]    r_best_idx;
    logic [KEY_BITS-1:0] r_best_key;
    logic [BYTES_W-1:0]  r_best_bytes;
    logic [STAMP_W-1:0]  r_best_stamp;
    logic [IDX_W-1:0]    r_free_idx;

    // response registers
    t_status             r_status, n_status;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic [VIS_W-1:0]    r_visits, n_visits;
    logic [KEY_BITS-1:0] r_evk, n_evk;
    logic [BYTES_W-1:0]  r_evb, n_evb;
    logic [BYTES_W-1:0]  r_used, n_biu;
    logic [CNT_W-1:0]    r_count, n_cnt;
    logic [STAMP_W-1:0]  n_stamp;

    // store ports
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [REC_W-1:0]    wr_data;
    logic [REC_W-1:0]    rd_data;
    logic                rd_valid;
    logic [KEY_BITS-1:0] rd_key;
    logic [BYTES_W-1:0]  rd_bytes;
    logic [VIS_W-1:0]    rd_visits;
    logic [STAMP_W-1:0]  rd_stamp;

    logic                take;
    t_rank               cand;

    logic                req_beat;
    logic [BYTES_W:0]    sum_free;
    logic                fits_free;
    logic signed [BYTES_W+1:0] sum_ev;
    logic                fits_ev;
    logic [VIS_W-1:0]    vis_inc;

    assign req_beat = i_req.valid && i_req.ready;
    assign {rd_valid, rd_key, rd_bytes, rd_visits, rd_stamp} = rd_data;

    sblfu_table #(
        .ENTRIES (ENTRIES),
        .REC_W   (REC_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    sblfu_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .i_mode_ins    (r_cmd == CMD_INSERT),
        .i_cand_valid  (rd_valid),
        .i_cand_key    (rd_key),
        .i_cand_visits (rd_visits),
        .i_cand_stamp  (rd_stamp),
        .i_key         (r_key),
        .i_next_stamp  (r_stamp),
        .i_best        (r_best),
        .o_take        (take),
        .o_cand        (cand)
    );

    // budget checks; a negative eviction sum means the pick outweighs use
    assign sum_free  = {1'b0, r_biu} + {1'b0, r_obj};
    assign fits_free = sum_free <= {1'b0, r_cap};
    assign sum_ev    = $signed({2'b00, r_biu}) - $signed({2'b00, r_best_bytes})
                     + $signed({2'b00, r_obj});
    assign fits_ev   = !sum_ev[BYTES_W+1] && (sum_ev[BYTES_W:0] <= {1'b0, r_cap});
    assign vis_inc   = (r_best.visits == VIS_MAX) ? VIS_MAX : r_best.visits + VIS_NEW;

    always_comb begin
        n_status = ST_MISS;
        n_slot   = '0;
        n_visits = '0;
        n_evk    = '0;
        n_evb    = '0;
        n_biu    = r_biu;
        n_cnt    = r_cnt;
        n_stamp  = r_stamp;
        wr_en    = 1'b0;
        wr_addr  = r_addr;
        wr_data  = '0;
        if (r_state == S_CLEAR) begin
            wr_en = 1'b1;
        end else if (r_state == S_DECIDE) begin
            if (r_cmd == CMD_LOOKUP) begin
                if (r_best.found) begin
                    n_status = ST_HIT;
                    n_slot   = r_best_idx;
                    n_visits = vis_inc;
                    wr_en    = 1'b1;
                    wr_addr  = r_best_idx;
                    wr_data  = {1'b1, r_best_key, r_best_bytes, vis_inc, r_best_stamp};
                end
            end else if (r_free_found && fits_free) begin
                n_status = ST_ADDED;
                n_slot   = r_free_idx;
                n_biu    = sum_free[BYTES_W-1:0];
                n_cnt    = r_cnt + CNT_W'(1);
                n_stamp  = r_stamp + STAMP_W'(1);
                wr_en    = 1'b1;
                wr_addr  = r_free_idx;
                wr_data  = {1'b1, r_key, r_obj, VIS_NEW, r_stamp};
            end else if (r_best.found && fits_ev) begin
                n_status = ST_EVICT;
                n_slot   = r_best_idx;
                n_evk    = r_best_key;
                n_evb    = r_best_bytes;
                n_biu    = sum_ev[BYTES_W-1:0];
                n_stamp  = r_stamp + STAMP_W'(1);
                wr_en    = 1'b1;
                wr_addr  = r_best_idx;
                wr_data  = {1'b1, r_key, r_obj, VIS_NEW, r_stamp};
            end else begin
                n_status = ST_REJECT;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_addr == IDX_LAST) n_state = S_IDLE;
            S_IDLE:   if (req_beat) n_state = S_SCAN;
            S_SCAN:   if (r_addr == IDX_LAST) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_DECIDE;
            S_DECIDE: n_state = S_OUT;
            S_OUT:    if (o_rsp.ready) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_dv         <= 1'b0;
            r_cap        <= CAP_RESET;
            r_stamp      <= '0;
            r_biu        <= '0;
            r_cnt        <= '0;
            r_best.found <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= (r_state == S_SCAN);
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_addr <= (r_addr == IDX_LAST) ? '0 : r_addr + IDX_W'(1);
            end
            if (req_beat) begin
                r_best.found <= 1'b0;
                r_free_found <= 1'b0;
            end
            if (r_dv) begin
                if (take) begin
                    r_best.found  <= 1'b1;
                    r_best.age    <= cand.age;
                    r_best.visits <= cand.visits;
                end
                if (!rd_valid) begin
                    r_free_found <= 1'b1;
                end
            end
            if (r_state == S_DECIDE) begin
                r_stamp <= n_stamp;
                r_biu   <= n_biu;
                r_cnt   <= n_cnt;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_didx <= r_addr;
        if (req_beat) begin
            r_cmd <= i_req.command;
            r_key <= i_req.key;
            r_obj <= i_req.object_bytes;
        end
        if (r_dv) begin
            if (take) begin
                r_best_idx    <= r_didx;
                r_best_key    <= rd_key;
                r_best_bytes  <= rd_bytes;
                r_best_stamp  <= rd_stamp;
            end
            // lowest free slot wins
            if (!rd_valid && !r_free_found) begin
                r_free_idx <= r_didx;
            end
        end
        if (r_state == S_DECIDE) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_visits <= n_visits;
            r_evk    <= n_evk;
            r_evb    <= n_evb;
            r_used   <= n_biu;
            r_count  <= n_cnt;
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = (r_state == S_OUT);
    assign o_rsp.status        = r_status;
    assign o_rsp.slot          = r_slot;
    assign o_rsp.visits        = r_visits;
    assign o_rsp.evicted_key   = r_evk;
    assign o_rsp.evicted_bytes = r_evb;
    assign o_rsp.used_bytes    = r_used;
    assign o_rsp.entry_count   = r_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(ENTRIES))
        else $error("valid entry count exceeds table depth");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request taken while a response is pending");

    a_scan_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !o_rsp.valid && !i_req.ready)
        else $error("request finished without a table scan");

    a_hit_visits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == ST_HIT) |-> (o_rsp.visits != '0))
        else $error("hit reported with zero visit count");

    a_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == ST_ADDED || o_rsp.status == ST_EVICT)
        |-> (o_rsp.used_bytes <= r_cap))
        else $error("insert accepted beyond byte budget");
`endif

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte-budget LFU cache metadata table. A tracker
// class mirrors the table (entries, age stamps, byte use, budget) and predicts
// every response beat. Requests come in random bursts, and the response side
// stalls on its own pattern. The budget is reprogrammed between phases.
// ----------------------------------------------------------------------------
module testbench;
    import sblfu_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int KEY_BITS    = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 180;
    localparam int POOL_SIZE   = 12;

    typedef struct {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [BYTES_W-1:0]  nbytes;
        logic [VIS_W-1:0]    visits;
        logic [STAMP_W-1:0]  stamp;
    } t_entry;

    typedef struct {
        t_status             status;
        logic [3:0]          slot;
        logic [VIS_W-1:0]    visits;
        logic [KEY_BITS-1:0] ev_key;
        logic [BYTES_W-1:0]  ev_bytes;
        logic [BYTES_W-1:0]  used;
        logic [4:0]          count;
    } t_outcome;

    class lfu_table_tracker;
        t_entry             ent[ENTRIES];
        logic [STAMP_W-1:0] next_stamp;
        logic [BYTES_W-1:0] used;
        logic [4:0]         count;
        logic [BYTES_W-1:0] capacity;
        t_outcome           pending_outcomes[$];
        int                 errors;

        function new();
            foreach (ent[i]) ent[i].valid = 1'b0;
            next_stamp = '0;
            used       = '0;
            count      = '0;
            capacity   = CAP_RESET;
            errors     = 0;
        endfunction

        function void set_capacity(logic [BYTES_W-1:0] v);
            capacity = v;
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction

        function logic [STAMP_W-1:0] age_of(int i);
            return next_stamp - ent[i].stamp;
        endfunction

        function void store(int i, logic [KEY_BITS-1:0] key, logic [BYTES_W-1:0] nbytes);
            ent[i].valid  = 1'b1;
            ent[i].key    = key;
            ent[i].nbytes = nbytes;
            ent[i].visits = VIS_NEW;
            ent[i].stamp  = next_stamp;
            next_stamp    = next_stamp + 1;
            used          = used + nbytes;
        endfunction

        function void note_request(t_cmd cmd, logic [KEY_BITS-1:0] key,
                                   logic [BYTES_W-1:0] nbytes);
            t_outcome    o;
            int          pick;
            int          free_slot;
            logic [31:0] wide_used;
            logic [31:0] wide_obj;
            logic [31:0] wide_cap;
            o.status   = ST_MISS;
            o.slot     = '0;
            o.visits   = '0;
            o.ev_key   = '0;
            o.ev_bytes = '0;
            pick       = -1;
            free_slot  = -1;
            wide_used  = {8'h0, used};
            wide_obj   = {8'h0, nbytes};
            wide_cap   = {8'h0, capacity};
            if (cmd == CMD_LOOKUP) begin
                // duplicates: the oldest matching entry wins
                for (int i = 0; i < ENTRIES; i++) begin
                    if (ent[i].valid && ent[i].key == key &&
                        (pick < 0 || age_of(i) > age_of(pick)))
                        pick = i;
                end
                if (pick >= 0) begin
                    if (ent[pick].visits != VIS_MAX) ent[pick].visits = ent[pick].visits + 1;
                    o.status = ST_HIT;
                    o.slot   = pick[3:0];
                    o.visits = ent[pick].visits;
                end
            end else begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!ent[i].valid) begin
                        free_slot = i;
                        break;
                    end
                end
                if (free_slot >= 0 && wide_used + wide_obj <= wide_cap) begin
                    store(free_slot, key, nbytes);
                    count    = count + 1;
                    o.status = ST_ADDED;
                    o.slot   = free_slot[3:0];
                end else begin
                    // victim: lowest count, oldest on ties
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (ent[i].valid &&
                            (pick < 0 || ent[i].visits < ent[pick].visits ||
                             (ent[i].visits == ent[pick].visits &&
                              age_of(i) > age_of(pick))))
                            pick = i;
                    end
                    if (pick < 0 ||
                        wide_used - {8'h0, ent[pick].nbytes} + wide_obj > wide_cap) begin
                        o.status = ST_REJECT;
                    end else begin
                        o.ev_key   = ent[pick].key;
                        o.ev_bytes = ent[pick].nbytes;
                        used       = used - ent[pick].nbytes;
                        store(pick, key, nbytes);
                        o.status   = ST_EVICT;
                        o.slot     = pick[3:0];
                    end
                end
            end
            o.used  = used;
            o.count = count;
            pending_outcomes.push_back(o);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task field_check(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_response(t_status status, logic [3:0] slot, logic [VIS_W-1:0] visits,
                            logic [KEY_BITS-1:0] ev_key, logic [BYTES_W-1:0] ev_bytes,
                            logic [BYTES_W-1:0] used_bytes, logic [4:0] entry_count);
            t_outcome o;
            if (pending_outcomes.size() == 0) begin
                report("response beat with no request outstanding");
            end else begin
                o = pending_outcomes.pop_front();
                field_check("status", 64'(status), 64'(o.status));
                field_check("slot", 64'(slot), 64'(o.slot));
                field_check("visits", 64'(visits), 64'(o.visits));
                field_check("evicted_key", ev_key, o.ev_key);
                field_check("evicted_bytes", 64'(ev_bytes), 64'(o.ev_bytes));
                field_check("used_bytes", 64'(used_bytes), 64'(o.used));
                field_check("entry_count", 64'(entry_count), 64'(o.count));
            end
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [BYTES_W-1:0] cfg_wdata;

    sblfu_req_if #(.KEY_BITS(KEY_BITS)) req ();
    sblfu_rsp_if #(.KEY_BITS(KEY_BITS), .SLOT_W(4), .CNT_W(5)) rsp ();

    size_budget_lfu_cache_table #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    lfu_table_tracker tracker;
    int               burst_left = 0;
    int               ready_left = 0;
    logic             ready_level = 1'b0;
    int               quiet_cycles = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // response side: long open stretches mixed with short random stalls
    always @(posedge clk) begin
        if (ready_left == 0) begin
            if ($urandom_range(0, 9) < 3) begin
                ready_level = 1'b1;
                ready_left  = $urandom_range(30, 60);
            end else begin
                ready_level = ~ready_level;
                ready_left  = ready_level ? $urandom_range(1, 6) : $urandom_range(1, 8);
            end
        end else begin
            ready_left--;
        end
        rsp.ready <= ready_level;
    end

    always @(posedge clk) begin
        if (rst_n && rsp.valid && rsp.ready)
            tracker.check_response(rsp.status, rsp.slot, rsp.visits, rsp.evicted_key,
                                   rsp.evicted_bytes, rsp.used_bytes, rsp.entry_count);
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(t_cmd cmd, logic [KEY_BITS-1:0] key,
                                logic [BYTES_W-1:0] nbytes);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid        <= 1'b1;
        req.command      <= cmd;
        req.key          <= key;
        req.object_bytes <= nbytes;
        do @(posedge clk); while (!req.ready);
        tracker.note_request(cmd, key, nbytes);
    endtask

    // quiesce before touching the budget register
    task automatic drain();
        req.valid  <= 1'b0;
        burst_left = 0;
        while (tracker.outstanding() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [BYTES_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        tracker.set_capacity(v);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [KEY_BITS-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [BYTES_W-1:0] random_size(logic [BYTES_W-1:0] cap);
        int r;
        int hi;
        r  = $urandom_range(0, 9);
        hi = int'(cap) / 5;
        if (hi < 3) hi = 3;
        if (r == 0) return '0;
        if (r == 1) return BYTES_W'($urandom);
        return BYTES_W'($urandom_range(0, hi));
    endfunction

    initial begin
        logic [KEY_BITS-1:0] k[16];
        logic [KEY_BITS-1:0] pool[POOL_SIZE];
        logic [BYTES_W-1:0]  caps[8];
        logic [KEY_BITS-1:0] key;
        t_cmd                cmd;
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.command      = CMD_LOOKUP;
        req.key          = '0;
        req.object_bytes = '0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        tracker          = new();
        foreach (k[i]) k[i] = random_key();
        caps = '{24'hFFFFFF, 24'd0, 24'd40000, CAP_RESET,
                 BYTES_W'($urandom), 24'd16, 24'd200000, 24'hFFFFFF};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_request(CMD_LOOKUP, '0, '0);             // empty table
        send_request(CMD_INSERT, '1, 24'hFFFFFF);     // too big, empty table
        send_request(CMD_INSERT, '0, '0);
        send_request(CMD_INSERT, k[1], 24'd100);
        send_request(CMD_INSERT, k[1], 24'd200);      // duplicate key
        send_request(CMD_LOOKUP, k[1], 24'hFFFFFF);   // oldest duplicate hit
        send_request(CMD_LOOKUP, '1, '0);
        for (int i = 2; i < 15; i++) send_request(CMD_INSERT, k[i], BYTES_W'(i * 1000));
        send_request(CMD_LOOKUP, '0, '0);
        send_request(CMD_INSERT, k[15], 24'd5);       // full table, tie on count
        send_request(CMD_INSERT, k[0], 24'hFFFFFF);   // eviction still over budget
        drain();
        write_capacity(24'd10);                       // below current use
        send_request(CMD_INSERT, k[3], 24'd1);
        send_request(CMD_LOOKUP, k[1], '0);

        foreach (caps[p]) begin
            drain();
            write_capacity(caps[p]);
            foreach (pool[j]) pool[j] = random_key();
            pool[0] = '0;
            pool[1] = '1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_LOOKUP;
                key = ($urandom_range(0, 4) == 0) ? random_key()
                                                  : pool[$urandom_range(0, POOL_SIZE - 1)];
                send_request(cmd, key, random_size(caps[p]));
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: size_budget_lfu_cache_table.f
rtl/sblfu_pkg.sv
rtl/sblfu_req_if.sv
rtl/sblfu_rsp_if.sv
rtl/sblfu_cmp.sv
rtl/sblfu_table.sv
rtl/size_budget_lfu_cache_table.sv
bench/testbench.sv
